// ----- sv/rse_pkg.sv -----
// ----------------------------------------------------------------------------
// rse_pkg
// shared types, codes and helpers for the rpn stack evaluator
// ----------------------------------------------------------------------------
`default_nettype none

package rse_pkg;

	// default number of stack entries
	localparam int STACK_DEPTH_DEF = 128;

	// q16.16 value that an empty pop reads as
	localparam logic [31:0] Q_NEG_ONE = 32'hFFFF_0000;

	// action codes
	localparam logic [3:0] ACT_PUSH   = 4'd0;
	localparam logic [3:0] ACT_ADD    = 4'd1;
	localparam logic [3:0] ACT_SUB    = 4'd2;
	localparam logic [3:0] ACT_MUL    = 4'd3;
	localparam logic [3:0] ACT_DIV    = 4'd4;
	localparam logic [3:0] ACT_DUP    = 4'd5;
	localparam logic [3:0] ACT_SWAP   = 4'd6;
	localparam logic [3:0] ACT_CLEAR  = 4'd7;
	localparam logic [3:0] ACT_FINISH = 4'd8;

	// status codes
	localparam logic [2:0] ST_OK      = 3'd0;
	localparam logic [2:0] ST_OVER    = 3'd1;
	localparam logic [2:0] ST_UNDER   = 3'd2;
	localparam logic [2:0] ST_DIVZ    = 3'd3;
	localparam logic [2:0] ST_SAT     = 3'd4;
	localparam logic [2:0] ST_INVALID = 3'd5;

	// result of an arithmetic unit
	typedef struct packed {
		logic        sat;
		logic [31:0] value;
	} op_res_t;

	// clamp a 48-bit signed value to the q16.16 range
	function automatic op_res_t sat_q48(input logic signed [47:0] v);
		op_res_t r;
		r.sat   = 1'b0;
		r.value = v[31:0];
		if (v > 48'sh0000_7FFF_FFFF) begin
			r.sat   = 1'b1;
			r.value = 32'h7FFF_FFFF;
		end else if (v < 48'shFFFF_8000_0000) begin
			r.sat   = 1'b1;
			r.value = 32'h8000_0000;
		end
		return r;
	endfunction

endpackage

`default_nettype wire

// ----- sv/rse_stack_ram.sv -----
// ----------------------------------------------------------------------------
// rse_stack_ram
// operand stack storage, one write port and one registered read port
// ----------------------------------------------------------------------------
`default_nettype none

module rse_stack_ram #(
	parameter int DEPTH = rse_pkg::STACK_DEPTH_DEF,
	parameter int AW    = $clog2(DEPTH)
) (
	input  wire logic          clk,
	input  wire logic          we,
	input  wire logic [AW-1:0] waddr,
	input  wire logic [31:0]   wdata,
	input  wire logic          re,
	input  wire logic [AW-1:0] raddr,
	output logic      [31:0]   rdata
);

	logic [31:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

// ----- sv/rse_mul.sv -----
// ----------------------------------------------------------------------------
// rse_mul
// two-stage q16.16 multiplier: product, then truncate toward zero and clamp
// ----------------------------------------------------------------------------
`default_nettype none

module rse_mul (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               start,
	input  wire logic signed [31:0] a,
	input  wire logic signed [31:0] b,
	output logic                    done,
	output rse_pkg::op_res_t        res
);

	logic               vld_s1;
	logic signed [63:0] prod_s1;
	logic               vld_s2;
	rse_pkg::op_res_t   res_s2;
	logic signed [47:0] quo;
	logic               rnd;

	always_ff @(posedge clk) begin
		if (start) begin
			prod_s1 <= a * b;
		end
	end

	// arithmetic shift floors, so bump negative inexact results toward zero
	assign rnd = prod_s1[63] && (prod_s1[15:0] != 16'd0);
	assign quo = prod_s1[63:16] + {47'd0, rnd};

	always_ff @(posedge clk) begin
		if (vld_s1) begin
			res_s2 <= rse_pkg::sat_q48(quo);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else begin
			vld_s1 <= start;
			vld_s2 <= vld_s1;
		end
	end

	assign done = vld_s2;
	assign res  = res_s2;

endmodule

`default_nettype wire

// ----- sv/rse_div.sv -----
// ----------------------------------------------------------------------------
// rse_div
// q16.16 divider, restoring, one quotient bit per cycle, truncates toward zero
// ----------------------------------------------------------------------------
`default_nettype none

module rse_div (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	input  wire logic [31:0] a,
	input  wire logic [31:0] b,
	output logic             done,
	output rse_pkg::op_res_t res
);

	localparam int QW = 48;
	localparam int CW = $clog2(QW);

	logic             busy_q;
	logic             fin_q;
	logic             done_q;
	logic [CW-1:0]    cnt_q;
	logic             neg_q;
	logic [QW-1:0]    quo_q;
	logic [31:0]      rem_q;
	logic [31:0]      dvs_q;
	rse_pkg::op_res_t res_q;

	logic [31:0]      a_mag;
	logic [31:0]      b_mag;
	logic [32:0]      rem_sh;
	logic [33:0]      diff;
	logic             ge;

	assign a_mag  = a[31] ? (~a + 32'd1) : a;
	assign b_mag  = b[31] ? (~b + 32'd1) : b;
	assign rem_sh = {rem_q, quo_q[QW-1]};
	assign diff   = {1'b0, rem_sh} - {2'b00, dvs_q};
	assign ge     = !diff[33];

	always_ff @(posedge clk) begin
		if (start) begin
			neg_q <= a[31] ^ b[31];
			quo_q <= {a_mag, 16'd0};
			rem_q <= 32'd0;
			dvs_q <= b_mag;
		end else if (busy_q) begin
			quo_q <= {quo_q[QW-2:0], ge};
			rem_q <= ge ? diff[31:0] : rem_sh[31:0];
		end
	end

	// sign and clamp the magnitude quotient
	always_ff @(posedge clk) begin
		if (fin_q) begin
			res_q.sat <= 1'b0;
			if (neg_q) begin
				if (quo_q > 48'h0000_8000_0000) begin
					res_q.sat   <= 1'b1;
					res_q.value <= 32'h8000_0000;
				end else begin
					res_q.value <= ~quo_q[31:0] + 32'd1;
				end
			end else begin
				if (quo_q > 48'h0000_7FFF_FFFF) begin
					res_q.sat   <= 1'b1;
					res_q.value <= 32'h7FFF_FFFF;
				end else begin
					res_q.value <= quo_q[31:0];
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			fin_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= fin_q;
			fin_q  <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(QW - 1);
			end else if (busy_q) begin
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					fin_q  <= 1'b1;
				end else begin
					cnt_q <= cnt_q - CW'(1);
				end
			end
		end
	end

	assign done = done_q;
	assign res  = res_q;

endmodule

`default_nettype wire

// ----- sv/rpn_stack_evaluator_top.sv -----
// ----------------------------------------------------------------------------
// rpn_stack_evaluator_top
// reverse polish evaluator over a bounded q16.16 operand stack
// ----------------------------------------------------------------------------
//
//  channel  handshake               payload
//  -------  ----------------------  ---------------------------------------
//  in       in_valid / in_ready     action, operand_value
//  out      out_valid / out_ready   top_value, stack_depth, status
//
//  one transaction in gives one transaction out. items are taken one at a time.
//  push, add, sub, dup, clear, finish and unknown actions go from exec to done;
//  swap adds a write state (two stack writes on the single write port), mul
//  waits on the two-stage multiplier, div on 48 quotient bits, one per cycle.
//  the stack memory needs no clearing pass: only entries below the depth
//  count are ever used. reset clears the depth count and control state.
//  a stalled out transaction holds the result register; the next in
//  transaction is still taken and its result waits until the register frees.
//
`default_nettype none

module rpn_stack_evaluator_top #(
	parameter int STACK_DEPTH = rse_pkg::STACK_DEPTH_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [3:0]  action,
	input  wire logic [30:0] operand_value,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [31:0]      top_value,
	output logic [7:0]       stack_depth,
	output logic [2:0]       status
);

	localparam int AW = $clog2(STACK_DEPTH);
	localparam int DW = $clog2(STACK_DEPTH + 1);

	// sequencer states
	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_EXEC = 3'd1;
	localparam logic [2:0] S_WAIT = 3'd2;
	localparam logic [2:0] S_SWAP = 3'd3;
	localparam logic [2:0] S_DONE = 3'd4;

	logic [2:0]    state_q, state_d;
	logic [3:0]    action_q;
	logic [30:0]   operand_q;
	logic [DW-1:0] depth_q, depth_d;
	logic [31:0]   top_q, top_d;     // cached copy of the top entry
	logic [2:0]    status_q, status_d;
	logic          under_q, under_d;
	logic [31:0]   swap_q, swap_d;   // old top, written below the new top

	logic          out_valid_q;
	logic [31:0]   top_value_q;
	logic [7:0]    stack_depth_q;
	logic [2:0]    status_out_q;

	// memory port
	logic          mem_we;
	logic [AW-1:0] mem_waddr;
	logic [31:0]   mem_wdata;
	logic          mem_re;
	logic [31:0]   mem_rdata;

	// arithmetic units
	logic              mul_start, mul_done;
	logic              div_start, div_done;
	rse_pkg::op_res_t  mul_res, div_res, unit_res, as_res;

	logic          in_acc;
	logic          full, empty, two;
	logic [DW-1:0] dm1, dm2;
	logic [DW-1:0] arith_depth;
	logic [AW-1:0] arith_waddr;
	logic signed [31:0] a_op, b_op;
	logic signed [47:0] a_ext, b_ext, sum48;
	logic          out_load;
	logic [31:0]   out_top;
	logic [DW+7:0] depth_ext;

	assign in_ready = (state_q == S_IDLE);
	assign in_acc   = in_valid && in_ready;

	assign full  = (depth_q == DW'(STACK_DEPTH));
	assign empty = (depth_q == '0);
	assign two   = (depth_q > DW'(1));
	assign dm1   = depth_q - DW'(1);
	assign dm2   = depth_q - DW'(2);

	// a binary op pops two and pushes one; short stacks still end with one entry
	assign arith_depth = two ? dm1 : DW'(1);
	assign arith_waddr = two ? dm2[AW-1:0] : '0;

	// second-from-top is read at accept, data is there in the exec cycle
	assign mem_re = in_acc;

	// operands: empty pops read as -1.0
	assign b_op = empty ? rse_pkg::Q_NEG_ONE : top_q;
	assign a_op = two ? mem_rdata : rse_pkg::Q_NEG_ONE;

	assign a_ext = {{16{a_op[31]}}, a_op};
	assign b_ext = {{16{b_op[31]}}, b_op};
	assign sum48 = (action_q == rse_pkg::ACT_SUB) ? (a_ext - b_ext) : (a_ext + b_ext);
	assign as_res = rse_pkg::sat_q48(sum48);

	assign unit_res = (action_q == rse_pkg::ACT_MUL) ? mul_res : div_res;

	rse_stack_ram #(
		.DEPTH (STACK_DEPTH),
		.AW    (AW)
	) u_ram (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.re    (mem_re),
		.raddr (dm2[AW-1:0]),
		.rdata (mem_rdata)
	);

	rse_mul u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (mul_start),
		.a      (a_op),
		.b      (b_op),
		.done   (mul_done),
		.res    (mul_res)
	);

	rse_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.a      (a_op),
		.b      (b_op),
		.done   (div_done),
		.res    (div_res)
	);

	// sequencer: read at accept, modify and write back, then present result
	always_comb begin
		state_d   = state_q;
		depth_d   = depth_q;
		top_d     = top_q;
		status_d  = status_q;
		under_d   = under_q;
		swap_d    = swap_q;
		mem_we    = 1'b0;
		mem_waddr = depth_q[AW-1:0];
		mem_wdata = top_q;
		mul_start = 1'b0;
		div_start = 1'b0;
		out_load  = 1'b0;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					state_d = S_EXEC;
				end
			end
			S_EXEC: begin
				state_d  = S_DONE;
				status_d = rse_pkg::ST_OK;
				case (action_q)
					rse_pkg::ACT_PUSH: begin
						if (full) begin
							status_d = rse_pkg::ST_OVER;
						end else begin
							mem_we    = 1'b1;
							mem_wdata = {1'b0, operand_q};
							top_d     = {1'b0, operand_q};
							depth_d   = depth_q + DW'(1);
						end
					end
					rse_pkg::ACT_ADD, rse_pkg::ACT_SUB: begin
						mem_we    = 1'b1;
						mem_waddr = arith_waddr;
						mem_wdata = as_res.value;
						top_d     = as_res.value;
						depth_d   = arith_depth;
						status_d  = !two ? rse_pkg::ST_UNDER :
							(as_res.sat ? rse_pkg::ST_SAT : rse_pkg::ST_OK);
					end
					rse_pkg::ACT_MUL: begin
						mul_start = 1'b1;
						under_d   = !two;
						state_d   = S_WAIT;
					end
					rse_pkg::ACT_DIV: begin
						// zero divisor: drop it, dividend becomes the top
						if (!empty && (top_q == 32'd0)) begin
							status_d = rse_pkg::ST_DIVZ;
							depth_d  = dm1;
							top_d    = mem_rdata;
						end else begin
							div_start = 1'b1;
							under_d   = !two;
							state_d   = S_WAIT;
						end
					end
					rse_pkg::ACT_DUP: begin
						if (empty) begin
							status_d = rse_pkg::ST_UNDER;
						end else if (full) begin
							status_d = rse_pkg::ST_OVER;
						end else begin
							mem_we  = 1'b1;
							depth_d = depth_q + DW'(1);
						end
					end
					rse_pkg::ACT_SWAP: begin
						if (two) begin
							mem_we    = 1'b1;
							mem_waddr = dm1[AW-1:0];
							mem_wdata = mem_rdata;
							top_d     = mem_rdata;
							swap_d    = top_q;
							state_d   = S_SWAP;
						end else begin
							status_d = rse_pkg::ST_UNDER;
						end
					end
					rse_pkg::ACT_CLEAR: begin
						depth_d = '0;
					end
					rse_pkg::ACT_FINISH: begin
						status_d = (depth_q == DW'(1)) ? rse_pkg::ST_OK : rse_pkg::ST_INVALID;
						depth_d  = '0;
					end
					default: begin
						status_d = rse_pkg::ST_INVALID;
					end
				endcase
			end
			S_WAIT: begin
				if (mul_done || div_done) begin
					mem_we    = 1'b1;
					mem_waddr = arith_waddr;
					mem_wdata = unit_res.value;
					top_d     = unit_res.value;
					depth_d   = arith_depth;
					status_d  = under_q ? rse_pkg::ST_UNDER :
						(unit_res.sat ? rse_pkg::ST_SAT : rse_pkg::ST_OK);
					state_d   = S_DONE;
				end
			end
			S_SWAP: begin
				mem_we    = 1'b1;
				mem_waddr = dm2[AW-1:0];
				mem_wdata = swap_q;
				state_d   = S_DONE;
			end
			S_DONE: begin
				// wait for the result register to free up
				if (!out_valid_q || out_ready) begin
					out_load = 1'b1;
					state_d  = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// finish reports the lone entry (still cached in top_q) or zero
	always_comb begin
		if (action_q == rse_pkg::ACT_FINISH) begin
			out_top = (status_q == rse_pkg::ST_OK) ? top_q : 32'd0;
		end else begin
			out_top = empty ? 32'd0 : top_q;
		end
	end

	assign depth_ext = {8'd0, depth_q};

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			depth_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			depth_q <= depth_d;
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (in_acc) begin
			action_q  <= action;
			operand_q <= operand_value;
		end
		top_q    <= top_d;
		status_q <= status_d;
		under_q  <= under_d;
		swap_q   <= swap_d;
		if (out_load) begin
			top_value_q   <= out_top;
			stack_depth_q <= depth_ext[7:0];
			status_out_q  <= status_q;
		end
	end

	assign out_valid   = out_valid_q;
	assign top_value   = top_value_q;
	assign stack_depth = stack_depth_q;
	assign status      = status_out_q;

`ifndef SYNTHESIS
	// depth count never passes the stack size
	a_depth_bound: assert property (@(posedge clk) disable iff (!arst_n)
		depth_q <= DW'(STACK_DEPTH))
		else $error("depth count beyond stack size");

	// unit results only arrive while the sequencer waits for them
	a_unit_done: assert property (@(posedge clk) disable iff (!arst_n)
		(mul_done || div_done) |-> (state_q == S_WAIT))
		else $error("arithmetic unit done outside wait state");

	// stack writes only in the modify and write-back states
	a_write_state: assert property (@(posedge clk) disable iff (!arst_n)
		mem_we |-> (state_q == S_EXEC || state_q == S_WAIT || state_q == S_SWAP))
		else $error("stack write outside write-back states");

	// an accepted transaction always goes straight to execution
	a_accept_exec: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc |=> (state_q == S_EXEC))
		else $error("accepted transaction did not start");
`endif

endmodule

`default_nettype wire

// ----- verif/tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// self-checking bench for the rpn stack evaluator: a scoreboard mirrors the
// q16.16 operand stack, predicts top, depth and status for every accepted
// transaction and matches them in order against the output channel
// ----------------------------------------------------------------------------

module tb;
	import rse_pkg::*;

	localparam int STACK_ENTRIES   = STACK_DEPTH_DEF;
	localparam int RANDOM_ITEMS    = 600;
	localparam int CALM_TAIL       = 80;      // last transactions sent with no idling
	localparam int HOLD_OFF_CYCLES = 200;     // long receiver stall during the fill
	localparam int DRAIN_CYCLES    = 120;     // covers a divide plus margin
	localparam int CYCLE_LIMIT     = 400000;

	// actions outside the defined set
	localparam logic [3:0] ACT_UNKNOWN_LO = 4'd9;
	localparam logic [3:0] ACT_UNKNOWN_HI = 4'd15;

	typedef struct {
		logic [31:0] top;
		logic [7:0]  depth;
		logic [2:0]  st;
	} rpn_result_t;

	// mirror of the operand stack plus the queue of results still owed
	class rpn_scoreboard;
		logic [31:0]  entries [STACK_ENTRIES];
		int unsigned  depth;
		rpn_result_t  pending[$];
		int unsigned  errors;
		int unsigned  checked;
		int unsigned  status_seen [8];

		function new();
			depth   = 0;
			errors  = 0;
			checked = 0;
			foreach (status_seen[i]) status_seen[i] = 0;
		endfunction

		function logic signed [31:0] pop_operand(inout bit under);
			if (depth > 0) begin
				depth--;
				return entries[depth];
			end
			under = 1'b1;
			return Q_NEG_ONE;
		endfunction

		function bit push_operand(input logic [31:0] v);
			if (depth < STACK_ENTRIES) begin
				entries[depth] = v;
				depth++;
				return 1'b1;
			end
			return 1'b0;
		endfunction

		function logic [31:0] clamp_q(input logic signed [63:0] v, inout bit sat);
			if (v > 64'sh0000_0000_7FFF_FFFF) begin
				sat = 1'b1;
				return 32'h7FFF_FFFF;
			end
			if (v < -64'sh0000_0000_8000_0000) begin
				sat = 1'b1;
				return 32'h8000_0000;
			end
			return v[31:0];
		endfunction

		// one evaluation step: update the mirror and queue the owed result
		function void note_input(input logic [3:0] act, input logic [30:0] opnd);
			rpn_result_t        res;
			logic signed [31:0] a, b;
			logic signed [63:0] wide;
			logic [31:0]        r;
			logic [31:0]        final_value;
			bit                 under, sat, have_final;
			under       = 1'b0;
			sat         = 1'b0;
			have_final  = 1'b0;
			final_value = '0;
			res.st      = ST_OK;
			case (act)
				ACT_PUSH: begin
					if (!push_operand({1'b0, opnd})) res.st = ST_OVER;
				end
				ACT_ADD, ACT_SUB, ACT_MUL: begin
					b = pop_operand(under);
					a = pop_operand(under);
					if (act == ACT_ADD) begin
						wide = a + b;
					end else if (act == ACT_SUB) begin
						wide = a - b;
					end else begin
						wide = a * b;
						wide = wide / 64'sd65536;
					end
					r = clamp_q(wide, sat);
					void'(push_operand(r));
					res.st = under ? ST_UNDER : (sat ? ST_SAT : ST_OK);
				end
				ACT_DIV: begin
					b = pop_operand(under);
					if (b == 0) begin
						res.st = ST_DIVZ;
					end else begin
						a    = pop_operand(under);
						wide = a * 64'sd65536;
						wide = wide / b;
						r    = clamp_q(wide, sat);
						void'(push_operand(r));
						res.st = under ? ST_UNDER : (sat ? ST_SAT : ST_OK);
					end
				end
				ACT_DUP: begin
					if (depth == 0) res.st = ST_UNDER;
					else if (depth >= STACK_ENTRIES) res.st = ST_OVER;
					else void'(push_operand(entries[depth - 1]));
				end
				ACT_SWAP: begin
					if (depth > 1) begin
						r                  = entries[depth - 1];
						entries[depth - 1] = entries[depth - 2];
						entries[depth - 2] = r;
					end else begin
						res.st = ST_UNDER;
					end
				end
				ACT_CLEAR: depth = 0;
				ACT_FINISH: begin
					have_final = 1'b1;
					if (depth == 1) final_value = entries[0];
					else res.st = ST_INVALID;
					depth = 0;
				end
				default: res.st = ST_INVALID;
			endcase
			if (have_final) res.top = final_value;
			else if (depth > 0) res.top = entries[depth - 1];
			else res.top = '0;
			res.depth = depth[7:0];
			pending.push_back(res);
		endfunction

		function void check_result(input logic [31:0] top, input logic [7:0] dep,
				input logic [2:0] st);
			rpn_result_t exp_res;
			checked++;
			status_seen[st]++;
			if (pending.size() == 0) begin
				$display("%0t ns: result with nothing owed, top %h depth %0d status %0d",
					$time, top, dep, st);
				errors++;
				return;
			end
			exp_res = pending.pop_front();
			if (top !== exp_res.top) begin
				$display("%0t ns: top_value mismatch, expected %h, got %h",
					$time, exp_res.top, top);
				errors++;
			end
			if (dep !== exp_res.depth) begin
				$display("%0t ns: stack_depth mismatch, expected %0d, got %0d",
					$time, exp_res.depth, dep);
				errors++;
			end
			if (st !== exp_res.st) begin
				$display("%0t ns: status mismatch, expected %0d, got %0d",
					$time, exp_res.st, st);
				errors++;
			end
		endfunction
	endclass

	// dut ports; the inputs are known from time zero
	logic        clk           = 1'b0;
	logic        arst_n        = 1'b0;
	logic        in_valid      = 1'b0;
	logic [3:0]  action        = ACT_PUSH;
	logic [30:0] operand_value = '0;
	logic        out_ready     = 1'b0;
	logic        in_ready;
	logic        out_valid;
	logic [31:0] top_value;
	logic [7:0]  stack_depth;
	logic [2:0]  status;

	rpn_scoreboard sb = new();

	// run control shared by the sender and receiver processes
	bit          steady        = 1'b0;   // no idling on either side
	bit          hold_off_req  = 1'b0;   // receiver stalls for HOLD_OFF_CYCLES
	int unsigned items_sent    = 0;

	logic [3:0] arith_ops [4] = '{ACT_ADD, ACT_SUB, ACT_MUL, ACT_DIV};

	rpn_stack_evaluator_top #(
		.STACK_DEPTH(STACK_ENTRIES)
	) dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.action       (action),
		.operand_value(operand_value),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.top_value    (top_value),
		.stack_depth  (stack_depth),
		.status       (status)
	);

	// 8 ns clock
	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// offer one transaction, optionally after a random gap, and wait for it
	// to be taken; valid only drops in the gap between transactions
	task automatic send_item(input logic [3:0] act, input logic [30:0] opnd);
		int gap;
		if (!steady && $urandom_range(0, 4) == 0) begin
			gap = $urandom_range(1, 11);
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid      <= 1'b1;
		action        <= act;
		operand_value <= opnd;
		do @(posedge clk); while (!in_ready);
		sb.note_input(act, opnd);
		items_sent++;
	endtask

	task automatic wait_results_drained();
		while (sb.pending.size() != 0) @(posedge clk);
	endtask

	// operand mix: mostly small values so products and quotients stay in
	// range, with the extremes, whole numbers and zero divisors mixed in
	function automatic logic [30:0] pick_operand();
		case ($urandom_range(0, 7))
			0:       return '0;
			1:       return 31'h7FFF_FFFF;
			2:       return 31'($urandom());
			3:       return 31'($urandom_range(0, 300) << 16);
			default: return 31'($urandom_range(0, 32'h0004_FFFF));
		endcase
	endfunction

	// a well formed expression with random content, sometimes bent by an
	// extra dup or swap, closed by finish or now and then by clear
	task automatic send_expression();
		int n_terms;
		int k;
		n_terms = $urandom_range(1, 6);
		send_item(ACT_PUSH, pick_operand());
		for (k = 1; k < n_terms; k++) begin
			send_item(ACT_PUSH, pick_operand());
			if ($urandom_range(0, 7) == 0)
				send_item($urandom_range(0, 1) ? ACT_DUP : ACT_SWAP, 31'($urandom()));
			send_item(arith_ops[2'($urandom_range(0, 3))], 31'($urandom()));
		end
		send_item($urandom_range(0, 9) == 0 ? ACT_CLEAR : ACT_FINISH, 31'($urandom()));
	endtask

	// result monitor: a transaction out is taken when valid and ready meet
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready)
			sb.check_result(top_value, stack_depth, status);
	end

	// receiver: random stall bursts, one long hold-off on request, and
	// always ready once the run goes steady
	initial begin
		int burst;
		@(posedge clk);
		while (!arst_n) @(posedge clk);
		forever begin
			@(posedge clk);
			if (hold_off_req) begin
				out_ready <= 1'b0;
				repeat (HOLD_OFF_CYCLES) @(posedge clk);
				hold_off_req = 1'b0;
				out_ready <= 1'b1;
			end else if (!steady && out_ready && $urandom_range(0, 5) == 0) begin
				burst = $urandom_range(1, 11);
				out_ready <= 1'b0;
				repeat (burst) @(posedge clk);
				out_ready <= 1'b1;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	// watchdog
	initial begin
		int unsigned cycle_count;
		for (cycle_count = 0; cycle_count < CYCLE_LIMIT; cycle_count++)
			@(posedge clk);
		$display("timeout after %0d cycles, %0d results still owed",
			CYCLE_LIMIT, sb.pending.size());
		$display("CHECKS FAILED");
		$finish;
	end

	// main sequence
	initial begin
		int k;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		// empty-stack corners: dup, swap and add with nothing to pop
		send_item(ACT_DUP, 31'h7FFF_FFFF);
		send_item(ACT_SWAP, 31'h0);
		send_item(ACT_ADD, 31'h0);           // -1.0 + -1.0 pushed, underflow
		send_item(ACT_FINISH, 31'h7FFF_FFFF);// single entry returned
		send_item(ACT_FINISH, 31'h0);        // empty stack: invalid expression

		// saturation at the high and low bound
		send_item(ACT_PUSH, 31'h7FFF_FFFF);
		send_item(ACT_DUP, 31'h0);
		send_item(ACT_ADD, 31'h0);
		send_item(ACT_PUSH, 31'h0);
		send_item(ACT_SWAP, 31'h0);
		send_item(ACT_SUB, 31'h0);           // second minus top
		send_item(ACT_PUSH, 31'h7FFF_FFFF);
		send_item(ACT_SUB, 31'h0);           // lands on the most negative value

		// zero divisor dropped, then div and mul that clamp low
		send_item(ACT_PUSH, 31'h0);
		send_item(ACT_DIV, 31'h0);
		send_item(ACT_PUSH, 31'h0000_8000);  // 0.5
		send_item(ACT_DIV, 31'h0);
		send_item(ACT_PUSH, 31'h0001_8000);  // 1.5
		send_item(ACT_MUL, 31'h0);
		send_item(ACT_SUB, 31'h0);           // one entry: -1.0 minus top, underflow
		send_item(ACT_UNKNOWN_LO, 31'h5555_5555);
		send_item(ACT_UNKNOWN_HI, 31'h2AAA_AAAA);
		send_item(ACT_PUSH, 31'h0003_0000);
		send_item(ACT_MUL, 31'h0);
		send_item(ACT_FINISH, 31'h0);

		// random phase, with the fill and long hold-off in the middle
		while (items_sent < RANDOM_ITEMS) begin
			if (items_sent >= RANDOM_ITEMS - CALM_TAIL)
				steady = 1'b1;
			if ($urandom_range(0, 9) < 7) begin
				send_expression();
			end else begin
				for (k = $urandom_range(1, 4); k > 0; k--)
					send_item(4'($urandom_range(0, 15)), 31'($urandom()));
			end

			if (items_sent >= RANDOM_ITEMS / 2 && items_sent < RANDOM_ITEMS / 2 + 20) begin
				// sender pauses until the output side has caught up
				in_valid <= 1'b0;
				@(posedge clk);
				wait_results_drained();
				send_item(ACT_CLEAR, 31'h0);
				// receiver stalls while pushes keep coming: the block backs up,
				// then the stack runs full and overflows
				hold_off_req = 1'b1;
				for (k = 0; k < STACK_ENTRIES + 2; k++)
					send_item(ACT_PUSH, pick_operand());
				send_item(ACT_DUP, 31'h0);         // full stack: overflow
				send_item(ACT_SWAP, 31'h0);
				send_item(ACT_MUL, 31'h0);
				send_item(ACT_FINISH, 31'h0);      // many entries: invalid
			end
		end

		in_valid <= 1'b0;
		@(posedge clk);
		wait_results_drained();
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("%0d transactions in, %0d results checked across all actions and unknown codes",
			items_sent, sb.checked);
		$display("status mix: ok %0d, overflow %0d, underflow %0d, div0 %0d, sat %0d, invalid %0d",
			sb.status_seen[ST_OK], sb.status_seen[ST_OVER], sb.status_seen[ST_UNDER],
			sb.status_seen[ST_DIVZ], sb.status_seen[ST_SAT], sb.status_seen[ST_INVALID]);
		if (sb.errors == 0 && sb.pending.size() == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

endmodule
